>>> src/jac_pkg.sv
// Shared types, register codes and reset constants for the joystick axis conditioner.
package jac_pkg;

   localparam int CHANNELS_DEF = 2;
   localparam int MAX_CHANNELS = 4;
   localparam int CH_IDX_W     = 2;
   localparam int DIV_STEPS    = 32;
   localparam int ADDR_W       = 6;
   localparam int DATA_W       = 64;

   localparam logic [2:0] REG_MID      = 3'd0;
   localparam logic [2:0] REG_DEADZONE = 3'd1;
   localparam logic [2:0] REG_LIMIT    = 3'd2;
   localparam logic [2:0] REG_MULT     = 3'd3;
   localparam logic [2:0] REG_DIVISOR  = 3'd4;
   localparam logic [2:0] REG_MODE     = 3'd5;
   localparam logic [2:0] REG_ACTIVE   = 3'd6;

   localparam logic [63:0] MULT_RESET    = 64'h0001_0001_0001_0001;
   localparam logic [63:0] DIVISOR_RESET = 64'h0001_0001_0001_0001;

   typedef struct packed {
      logic [63:0] mid;
      logic [63:0] deadzone;
      logic [63:0] limit;
      logic [63:0] mult;
      logic [63:0] divisor;
      logic [7:0]  mode;
      logic        active;
   } cfg_type;

   typedef struct packed {
      logic                load;
      logic                cond;
      logic                mul;
      logic                div_step;
      logic                update;
      logic                emit;
      logic [CH_IDX_W-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0] changed;
   } stat_type;

endpackage

>>> src/jac_ctrl.sv
// Sequencer that walks each item through conditioning, multiply, division, update and, when active, reporting.
module jac_ctrl #(
   parameter int CHANNELS = jac_pkg::CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              active,
   input  jac_pkg::stat_type stat,
   output jac_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COND,
      ST_MUL,
      ST_DIV,
      ST_UPD,
      ST_RPT
   } state_type;

   localparam logic [jac_pkg::CH_IDX_W-1:0] LAST_CH = jac_pkg::CH_IDX_W'(CHANNELS - 1);
   localparam logic [4:0] LAST_STEP = 5'(jac_pkg::DIV_STEPS - 1);

   state_type                      state_ff, state_in;
   logic [jac_pkg::CH_IDX_W-1:0]   ch_ff, ch_in;
   logic [4:0]                     cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;
   logic                           emit;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit = (state_ff == ST_RPT) && stat.changed[ch_ff] && out_free;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in    = '0;
               state_in = ST_COND;
            end
         end
         ST_COND: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (ch_ff == LAST_CH) begin
               ch_in    = '0;
               state_in = active ? ST_RPT : ST_IDLE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_COND;
            end
         end
         ST_RPT: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
            end
            if (!stat.changed[ch_ff] || out_free) begin
               if (ch_ff == LAST_CH) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.cond     = (state_ff == ST_COND);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.update   = (state_ff == ST_UPD);
      cmd.emit     = emit;
      cmd.ch       = ch_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/jac_dpath.sv
// Channel conditioning datapath with multiplier, serial divider, totals and report registers.
module jac_dpath #(
   parameter int CHANNELS = jac_pkg::CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  jac_pkg::cmd_type   cmd,
   input  jac_pkg::cfg_type   cfg,
   input  logic [15:0]        sample_mv_0,
   input  logic [15:0]        sample_mv_1,
   input  logic [15:0]        sample_mv_2,
   input  logic [15:0]        sample_mv_3,
   output jac_pkg::stat_type  stat,
   output logic [1:0]         rsp_channel,
   output logic signed [31:0] rsp_value,
   output logic               rsp_last
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [15:0]        samp_ff [CHANNELS];
   logic signed [31:0] pend_ff [CHANNELS];
   logic signed [31:0] rep_ff [CHANNELS];
   logic               sign_ff;
   logic [15:0]        mag_ff;
   logic [31:0]        dvd_ff;
   logic [15:0]        rem_ff;
   logic [1:0]         rsp_channel_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic [CH_W-1:0]    ci;
   logic [15:0]        s_mv, mid, dz, lim, mult, dvs_raw;
   logic [15:0]        dvs;
   logic signed [17:0] d, v1, v2, v3, v4, dzs, lims;
   logic               invert, onchange;
   logic [31:0]        prod;
   logic [16:0]        rem_sh;
   logic               qbit;
   logic signed [17:0] cv;
   logic signed [32:0] sum;
   logic signed [31:0] acc;
   logic [CHANNELS-1:0] changed;
   logic               higher;

   function automatic logic [15:0] all_samp_sel(input int idx);
      logic [15:0] r;
      case (idx)
         0:       r = sample_mv_0;
         1:       r = sample_mv_1;
         2:       r = sample_mv_2;
         default: r = sample_mv_3;
      endcase
      return r;
   endfunction

   assign ci = cmd.ch[CH_W-1:0];

   always_comb begin
      mid      = cfg.mid[16*cmd.ch +: 16];
      dz       = cfg.deadzone[16*cmd.ch +: 16];
      lim      = cfg.limit[16*cmd.ch +: 16];
      mult     = cfg.mult[16*cmd.ch +: 16];
      dvs_raw  = cfg.divisor[16*cmd.ch +: 16];
      dvs      = (dvs_raw == 16'd0) ? 16'd1 : dvs_raw;
      invert   = cfg.mode[cmd.ch];
      onchange = cfg.mode[3'(cmd.ch) + 3'd4];
      s_mv     = samp_ff[ci];
   end

   always_comb begin
      dzs  = $signed({2'b00, dz});
      lims = $signed({2'b00, lim});
      d    = $signed({2'b00, s_mv}) - $signed({2'b00, mid});
      if (d > 18'sd32767) begin
         v1 = 18'sd32767;
      end else if (d < -18'sd32768) begin
         v1 = -18'sd32768;
      end else begin
         v1 = d;
      end
      v2 = v1;
      if (dz != 16'd0) begin
         if (v1 > 18'sd0) begin
            v2 = (v1 < dzs) ? 18'sd0 : v1 - dzs;
         end else if (v1 < 18'sd0) begin
            v2 = (v1 > -dzs) ? 18'sd0 : v1 + dzs;
         end
      end
      v3 = v2;
      if (lim != 16'd0) begin
         if (v2 > lims) begin
            v3 = lims;
         end else if (v2 < -lims) begin
            v3 = -lims;
         end
      end
      v4 = invert ? -v3 : v3;
   end

   assign prod   = {16'd0, mag_ff} * {16'd0, mult};
   assign rem_sh = {rem_ff, dvd_ff[31]};
   assign qbit   = (rem_sh >= {1'b0, dvs});

   always_comb begin
      if (!sign_ff) begin
         cv = (dvd_ff > 32'd32767) ? 18'sd32767 : $signed({2'b00, dvd_ff[15:0]});
      end else begin
         cv = (dvd_ff > 32'd32768) ? -18'sd32768 : -$signed({1'b0, dvd_ff[16:0]});
      end
      sum = {pend_ff[ci][31], pend_ff[ci]} + {{15{cv[17]}}, cv};
      if (sum[32] != sum[31]) begin
         acc = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         acc = sum[31:0];
      end
   end

   always_comb begin
      higher = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         changed[i] = (pend_ff[i] != rep_ff[i]);
         if (i > int'(cmd.ch) && changed[i]) begin
            higher = 1'b1;
         end
      end
      stat.changed = '0;
      stat.changed[CHANNELS-1:0] = changed;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < CHANNELS; i++) begin
            samp_ff[i] <= all_samp_sel(i);
         end
      end
      if (cmd.cond) begin
         sign_ff <= v4[17];
         mag_ff  <= v4[17] ? 16'(-v4) : v4[15:0];
      end
      if (cmd.mul) begin
         dvd_ff <= prod;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[30:0], qbit};
         rem_ff <= qbit ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
      end
      if (cmd.emit) begin
         rsp_channel_ff <= cmd.ch;
         rsp_value_ff   <= pend_ff[ci];
         rsp_last_ff    <= !higher;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pend_ff[i] <= '0;
            rep_ff[i]  <= '0;
         end
      end else if (cmd.update) begin
         pend_ff[ci] <= onchange ? {{14{cv[17]}}, cv} : acc;
      end else if (cmd.emit) begin
         pend_ff[ci] <= '0;
         if (onchange) begin
            rep_ff[ci] <= pend_ff[ci];
         end
      end
   end

   assign rsp_channel = rsp_channel_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

>>> src/joystick_axis_conditioner.sv
// Top level: register file, sequencer and datapath of the joystick axis conditioner.
// An item is taken only while the block is idle; each channel then goes through conditioning,
// multiply, a 32-step serial divide and a total update in turn, and when active a report
// scan over the channels follows. The serial divider is shared by all channels; a stalled
// result holds the report scan until the result is taken.
// Synchronous reset clears the registers to their defaults and all totals to zero at once.
module joystick_axis_conditioner #(
   parameter int CHANNELS = jac_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [15:0]                 req_sample_mv_0,
   input  logic [15:0]                 req_sample_mv_1,
   input  logic [15:0]                 req_sample_mv_2,
   input  logic [15:0]                 req_sample_mv_3,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_channel,
   output logic signed [31:0]          rsp_value,
   output logic                        rsp_last,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [jac_pkg::ADDR_W-1:0]  paddr,
   input  logic [jac_pkg::DATA_W-1:0]  pwdata,
   output logic [jac_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   jac_pkg::cfg_type  cfg_ff, cfg_in;
   jac_pkg::cmd_type  cmd;
   jac_pkg::stat_type stat;
   logic              wr;
   logic [2:0]        idx;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[5:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            jac_pkg::REG_MID:      cfg_in.mid      = pwdata;
            jac_pkg::REG_DEADZONE: cfg_in.deadzone = pwdata;
            jac_pkg::REG_LIMIT:    cfg_in.limit    = pwdata;
            jac_pkg::REG_MULT:     cfg_in.mult     = pwdata;
            jac_pkg::REG_DIVISOR:  cfg_in.divisor  = pwdata;
            jac_pkg::REG_MODE:     cfg_in.mode     = pwdata[7:0];
            jac_pkg::REG_ACTIVE:   cfg_in.active   = pwdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mid      <= '0;
         cfg_ff.deadzone <= '0;
         cfg_ff.limit    <= '0;
         cfg_ff.mult     <= jac_pkg::MULT_RESET;
         cfg_ff.divisor  <= jac_pkg::DIVISOR_RESET;
         cfg_ff.mode     <= '0;
         cfg_ff.active   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         jac_pkg::REG_MID:      prdata = cfg_ff.mid;
         jac_pkg::REG_DEADZONE: prdata = cfg_ff.deadzone;
         jac_pkg::REG_LIMIT:    prdata = cfg_ff.limit;
         jac_pkg::REG_MULT:     prdata = cfg_ff.mult;
         jac_pkg::REG_DIVISOR:  prdata = cfg_ff.divisor;
         jac_pkg::REG_MODE:     prdata = {56'd0, cfg_ff.mode};
         jac_pkg::REG_ACTIVE:   prdata = {63'd0, cfg_ff.active};
         default:               prdata = '0;
      endcase
   end

   jac_ctrl #(
      .CHANNELS(CHANNELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .active    (cfg_ff.active),
      .stat      (stat),
      .cmd       (cmd)
   );

   jac_dpath #(
      .CHANNELS(CHANNELS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg_ff),
      .sample_mv_0 (req_sample_mv_0),
      .sample_mv_1 (req_sample_mv_1),
      .sample_mv_2 (req_sample_mv_2),
      .sample_mv_3 (req_sample_mv_3),
      .stat        (stat),
      .rsp_channel (rsp_channel),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_last)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took an item without going busy");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_channel) < CHANNELS))
      else $error("report names a channel beyond the channel count");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("reset did not leave the block idle and empty");

   a_emit_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("report loaded over a result still waiting");

endmodule
